// File: design/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define FDSUM_ASSERT(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// Shorthand for modules whose clock is clk and whose reset is arst_n.
`define FDSUM_CHECK(label, prop, msg) \
	`FDSUM_ASSERT(label, clk, arst_n, prop, msg)

`endif

// File: design/fdsum_pkg.sv
// Package with the constants and types of the frame deframer.
`timescale 1ns / 1ps

package fdsum_pkg;

	localparam int MAX_CONTENT = 256;
	localparam int LEN_W       = $clog2(MAX_CONTENT + 1);
	localparam int BYTE_W      = 8;
	localparam int WORD_W      = 16;
	localparam int FLEN_W      = 9;

	localparam logic [BYTE_W-1:0] HEAD_MAGIC = 8'hFA;
	localparam logic [BYTE_W-1:0] END_MAGIC  = 8'hFC;
	localparam logic [BYTE_W-1:0] SHB_RESET  = 8'h5A;

	// APB register map: one register at byte address zero.
	localparam int PADDR_W = 1;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] REG_SECOND_HEAD = 1'b0;

	typedef struct packed {
		logic              frame_done;
		logic              content_valid;
		logic [BYTE_W-1:0] content_index;
		logic [BYTE_W-1:0] content_byte;
		logic [WORD_W-1:0] frame_command;
		logic [FLEN_W-1:0] frame_length;
		logic [BYTE_W-1:0] flag_byte;
	} result_t;

endpackage

// File: design/fdsum_if.sv
// Valid/ready channel interfaces for received bytes and parse results.
`timescale 1ns / 1ps

interface fdsum_in_if;
	logic                      valid;
	logic                      ready;
	logic [fdsum_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface fdsum_out_if;
	logic                          valid;
	logic                          ready;
	logic                          frame_done;
	logic                          content_valid;
	logic [fdsum_pkg::BYTE_W-1:0] content_index;
	logic [fdsum_pkg::BYTE_W-1:0] content_byte;
	logic [fdsum_pkg::WORD_W-1:0] frame_command;
	logic [fdsum_pkg::FLEN_W-1:0] frame_length;
	logic [fdsum_pkg::BYTE_W-1:0] flag_byte;

	modport source (output valid, output frame_done, output content_valid,
		output content_index, output content_byte, output frame_command,
		output frame_length, output flag_byte, input ready);
	modport sink (input valid, input frame_done, input content_valid,
		input content_index, input content_byte, input frame_command,
		input frame_length, input flag_byte, output ready);
endinterface

// File: design/fdsum_cfg.sv
// APB register block holding the expected second head byte.
`timescale 1ns / 1ps

module fdsum_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fdsum_pkg::PADDR_W-1:0]   paddr,
	input  logic [fdsum_pkg::PDATA_W-1:0]   pwdata,
	output logic [fdsum_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready,
	output logic [fdsum_pkg::BYTE_W-1:0]    second_head_byte
);

	logic [fdsum_pkg::BYTE_W-1:0] shb_q;
	logic                         wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shb_q <= fdsum_pkg::SHB_RESET;
		end else if (wr_en && (paddr == fdsum_pkg::REG_SECOND_HEAD)) begin
			shb_q <= pwdata[fdsum_pkg::BYTE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == fdsum_pkg::REG_SECOND_HEAD) begin
			prdata = fdsum_pkg::PDATA_W'(shb_q);
		end
	end

	assign second_head_byte = shb_q;

endmodule

// File: design/fdsum_parser.sv
// Frame parser: phase register, running checksum and per-byte result.
`timescale 1ns / 1ps

module fdsum_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [fdsum_pkg::BYTE_W-1:0]  second_head_byte,
	input  logic                          accept,
	input  logic [fdsum_pkg::BYTE_W-1:0]  rx_byte,
	output fdsum_pkg::result_t            result
);

	localparam logic [3:0] PH_HEAD1   = 4'd0;
	localparam logic [3:0] PH_HEAD2   = 4'd1;
	localparam logic [3:0] PH_LEN1    = 4'd2;
	localparam logic [3:0] PH_LEN2    = 4'd3;
	localparam logic [3:0] PH_CMD1    = 4'd4;
	localparam logic [3:0] PH_CMD2    = 4'd5;
	localparam logic [3:0] PH_CONTENT = 4'd6;
	localparam logic [3:0] PH_FLAG    = 4'd7;
	localparam logic [3:0] PH_CS1     = 4'd8;
	localparam logic [3:0] PH_CS2     = 4'd9;
	localparam logic [3:0] PH_END     = 4'd10;

	logic [3:0]                        phase_q, phase_d;
	logic [fdsum_pkg::LEN_W-1:0]       count_q, count_d, count_inc;
	logic [fdsum_pkg::BYTE_W-1:0]      len_lo_q, len_lo_d;
	logic [fdsum_pkg::LEN_W-1:0]       len_q, len_d;
	logic [fdsum_pkg::WORD_W-1:0]      cmd_q, cmd_d;
	logic [fdsum_pkg::BYTE_W-1:0]      flag_q, flag_d;
	logic [fdsum_pkg::BYTE_W-1:0]      cs_lo_q, cs_lo_d;
	logic [fdsum_pkg::WORD_W-1:0]      sum_q, sum_d;
	logic [fdsum_pkg::WORD_W-1:0]      sum_byte;
	logic [fdsum_pkg::WORD_W-1:0]      rx_word;

	assign sum_byte  = sum_q + fdsum_pkg::WORD_W'(rx_byte);
	assign count_inc = count_q + fdsum_pkg::LEN_W'(1);

	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		len_lo_d = len_lo_q;
		len_d    = len_q;
		cmd_d    = cmd_q;
		flag_d   = flag_q;
		cs_lo_d  = cs_lo_q;
		sum_d    = sum_q;
		rx_word  = '0;
		result   = '0;
		case (phase_q)
			PH_HEAD2: begin
				if (rx_byte == second_head_byte) begin
					sum_d   = fdsum_pkg::WORD_W'(fdsum_pkg::HEAD_MAGIC)
						+ fdsum_pkg::WORD_W'(rx_byte);
					phase_d = PH_LEN1;
				end else begin
					phase_d = PH_HEAD1;
				end
			end
			PH_LEN1: begin
				len_lo_d = rx_byte;
				sum_d    = sum_byte;
				phase_d  = PH_LEN2;
			end
			PH_LEN2: begin
				rx_word = {rx_byte, len_lo_q};
				sum_d   = sum_byte;
				if (rx_word > fdsum_pkg::WORD_W'(fdsum_pkg::MAX_CONTENT)) begin
					phase_d = PH_HEAD1;
				end else begin
					len_d   = fdsum_pkg::LEN_W'(rx_word);
					phase_d = PH_CMD1;
				end
			end
			PH_CMD1: begin
				cmd_d   = fdsum_pkg::WORD_W'(rx_byte);
				phase_d = PH_CMD2;
			end
			PH_CMD2: begin
				rx_word = {rx_byte, cmd_q[fdsum_pkg::BYTE_W-1:0]};
				cmd_d   = rx_word;
				sum_d   = sum_q + rx_word;
				count_d = '0;
				phase_d = (len_q != '0) ? PH_CONTENT : PH_FLAG;
			end
			PH_CONTENT: begin
				result.content_valid = 1'b1;
				result.content_index = fdsum_pkg::BYTE_W'(count_q);
				result.content_byte  = rx_byte;
				sum_d   = sum_byte;
				count_d = count_inc;
				if (count_inc >= len_q) begin
					phase_d = PH_FLAG;
				end
			end
			PH_FLAG: begin
				flag_d  = rx_byte;
				sum_d   = sum_byte;
				phase_d = PH_CS1;
			end
			PH_CS1: begin
				cs_lo_d = rx_byte;
				phase_d = PH_CS2;
			end
			PH_CS2: begin
				rx_word = {rx_byte, cs_lo_q};
				phase_d = (sum_q == rx_word) ? PH_END : PH_HEAD1;
			end
			PH_END: begin
				if (rx_byte == fdsum_pkg::END_MAGIC) begin
					result.frame_done    = 1'b1;
					result.frame_command = cmd_q;
					result.frame_length  = fdsum_pkg::FLEN_W'(len_q);
					result.flag_byte     = flag_q;
				end
				phase_d = PH_HEAD1;
			end
			default: begin
				phase_d = (rx_byte == fdsum_pkg::HEAD_MAGIC) ? PH_HEAD2 : PH_HEAD1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEAD1;
			count_q  <= '0;
			len_lo_q <= '0;
			len_q    <= '0;
			cmd_q    <= '0;
			flag_q   <= '0;
			cs_lo_q  <= '0;
			sum_q    <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			len_lo_q <= len_lo_d;
			len_q    <= len_d;
			cmd_q    <= cmd_d;
			flag_q   <= flag_d;
			cs_lo_q  <= cs_lo_d;
			sum_q    <= sum_d;
		end
	end

endmodule

// File: design/fdsum_out_buf.sv
// Two-entry output register with a skid stage between parser and receiver.
`timescale 1ns / 1ps

module fdsum_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  fdsum_pkg::result_t  push_data,
	output logic                pop_valid,
	input  logic                pop_ready,
	output fdsum_pkg::result_t  pop_data
);

	logic               out_valid_q;
	logic               skid_valid_q;
	fdsum_pkg::result_t out_q;
	fdsum_pkg::result_t skid_q;
	logic               push;
	logic               out_free;

	assign push_ready = ~skid_valid_q;
	assign push       = push_valid & push_ready;
	assign out_free   = ~out_valid_q | pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign pop_valid = out_valid_q;
	assign pop_data  = out_q;

endmodule

// File: design/frame_deframer_with_sum16_unit.sv
// Top level of the frame deframer with a 16-bit additive checksum.
`timescale 1ns / 1ps

// Usage:
// Received bytes come in one transaction at a time on the rx channel. Every
// accepted byte yields exactly one transaction on the res channel: content
// bytes carry content_valid with their index, the end byte of a good frame
// carries frame_done with the command, length and flag byte, and every other
// byte gives an all-zero result. A receiver keeps content only once it sees
// frame_done; a bad checksum or end byte simply never produces it.
// Throughput is one byte per cycle while rx.ready is high, set by the single
// parser register stage with its phase update and one 16-bit add. When the
// receiver stalls, the output register holds its result and one more byte
// is taken into the skid stage; rx.ready falls only when both are full and
// rises again the cycle after the receiver takes a result. The expected
// second head byte is written over the APB port at address 0 while the block
// is idle, as the user must ensure; the block does not enforce it. Reset
// sets it to 0x5A, puts the parser back to hunting for the first head byte
// and empties the output stages.

module frame_deframer_with_sum16_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	fdsum_in_if.sink                       rx,
	fdsum_out_if.source                    res,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [fdsum_pkg::PADDR_W-1:0]  paddr,
	input  logic [fdsum_pkg::PDATA_W-1:0]  pwdata,
	output logic [fdsum_pkg::PDATA_W-1:0]  prdata,
	output logic                           pready
);

	logic [fdsum_pkg::BYTE_W-1:0] second_head_byte;
	logic                         rx_ready;
	logic                         rx_accept;
	fdsum_pkg::result_t           parse_result;
	fdsum_pkg::result_t           res_data;

	// Register block for the configurable second head byte.
	fdsum_cfg u_cfg (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.second_head_byte (second_head_byte)
	);

	// A byte is taken whenever the output stages have room; the parser
	// advances its state on that same edge.
	assign rx.ready  = rx_ready;
	assign rx_accept = rx.valid & rx_ready;

	fdsum_parser u_parser (
		.clk              (clk),
		.arst_n           (arst_n),
		.second_head_byte (second_head_byte),
		.accept           (rx_accept),
		.rx_byte          (rx.rx_byte),
		.result           (parse_result)
	);

	// The result of each accepted byte is registered here and held while
	// the receiver stalls.
	fdsum_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (rx.valid),
		.push_ready (rx_ready),
		.push_data  (parse_result),
		.pop_valid  (res.valid),
		.pop_ready  (res.ready),
		.pop_data   (res_data)
	);

	assign res.frame_done    = res_data.frame_done;
	assign res.content_valid = res_data.content_valid;
	assign res.content_index = res_data.content_index;
	assign res.content_byte  = res_data.content_byte;
	assign res.frame_command = res_data.frame_command;
	assign res.frame_length  = res_data.frame_length;
	assign res.flag_byte     = res_data.flag_byte;

endmodule

// File: design/fdsum_checker.sv
// Port-level checker for the frame deframer and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fdsum_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          frame_done,
	input logic                          content_valid,
	input logic [fdsum_pkg::BYTE_W-1:0]  content_index,
	input logic [fdsum_pkg::BYTE_W-1:0]  content_byte,
	input logic [fdsum_pkg::WORD_W-1:0]  frame_command,
	input logic [fdsum_pkg::FLEN_W-1:0]  frame_length,
	input logic [fdsum_pkg::BYTE_W-1:0]  flag_byte
);

	// A result is either a content byte, a completed frame or neither.
	`FDSUM_CHECK(a_done_content_excl, out_valid |-> !(frame_done && content_valid), "frame_done and content_valid together")

	// Frame fields are only nonzero on a completed frame.
	`FDSUM_CHECK(a_frame_fields_zero, (out_valid && !frame_done) |-> (frame_command == '0 && frame_length == '0 && flag_byte == '0), "frame fields set without frame_done")

	// Content fields are only nonzero on a content byte.
	`FDSUM_CHECK(a_content_fields_zero, (out_valid && !content_valid) |-> (content_index == '0 && content_byte == '0), "content fields set without content_valid")

	// A stalled result stays offered.
	`FDSUM_CHECK(a_out_hold, (out_valid && !out_ready) |=> out_valid, "result withdrawn while stalled")

endmodule

bind frame_deframer_with_sum16_unit fdsum_checker u_fdsum_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (res.valid),
	.out_ready     (res.ready),
	.frame_done    (res.frame_done),
	.content_valid (res.content_valid),
	.content_index (res.content_index),
	.content_byte  (res.content_byte),
	.frame_command (res.frame_command),
	.frame_length  (res.frame_length),
	.flag_byte     (res.flag_byte)
);

// File: test/testbench.sv
// Self-checking testbench for the frame deframer with a 16-bit additive checksum.
`timescale 1ns / 1ps

module testbench;

	// Parser phases of the local predictor, in the order a frame walks through them.
	typedef enum logic [3:0] {
		PH_WAIT_MAGIC, PH_WAIT_HEAD2, PH_LEN_LO, PH_LEN_HI, PH_CMD_LO, PH_CMD_HI,
		PH_CONTENT, PH_FLAG, PH_SUM_LO, PH_SUM_HI, PH_END
	} parse_phase_t;

	// Ways a generated frame can be spoiled on purpose.
	typedef enum {
		FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_END, FRAME_BAD_HEAD, FRAME_TOO_LONG
	} frame_defect_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Every input of the block starts from a known value at time zero.
	logic                          in_valid = 1'b0;
	logic [fdsum_pkg::BYTE_W-1:0]  in_byte = '0;
	logic                          out_ready = 1'b0;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [fdsum_pkg::PADDR_W-1:0] paddr = '0;
	logic [fdsum_pkg::PDATA_W-1:0] pwdata = '0;
	logic [fdsum_pkg::PDATA_W-1:0] prdata;
	logic                          pready;

	fdsum_in_if  rx_ch ();
	fdsum_out_if res_ch ();

	assign rx_ch.valid   = in_valid;
	assign rx_ch.rx_byte = in_byte;
	assign res_ch.ready  = out_ready;

	frame_deframer_with_sum16_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Bytes waiting to be offered, and parse results waiting to be seen.
	logic [fdsum_pkg::BYTE_W-1:0] pending_bytes[$];
	fdsum_pkg::result_t           expected_results[$];

	// Mirror of the parser state and of the second head byte register.
	parse_phase_t      phase_q = PH_WAIT_MAGIC;
	logic [15:0]       count_q = '0;
	logic [15:0]       length_q = '0;
	logic [15:0]       command_q = '0;
	logic [7:0]        flag_q = '0;
	logic [7:0]        sum_low_q = '0;
	logic [15:0]       sum_q = '0;
	logic [7:0]        head2_cfg = fdsum_pkg::SHB_RESET;

	int                 error_count = 0;
	int                 bytes_taken = 0;
	int                 send_gap = 0;
	int                 stall_gap = 0;
	logic               hold_off = 1'b0;
	logic               quiet = 1'b0;
	fdsum_pkg::result_t got;
	fdsum_pkg::result_t want;

	task automatic report_error(input string msg);
		$display("%0t: MISMATCH %s", $realtime, msg);
		error_count++;
	endtask

	// Advances the mirrored parser by one received byte and returns the
	// result transaction the block must produce for it.
	function automatic fdsum_pkg::result_t parse_byte(input logic [7:0] b);
		fdsum_pkg::result_t r;
		r = '0;
		case (phase_q)
		PH_WAIT_HEAD2: begin
			// A wrong second head byte is dropped, not retried as a magic byte.
			if (b == head2_cfg) begin
				sum_q = fdsum_pkg::HEAD_MAGIC + b;
				phase_q = PH_LEN_LO;
			end else begin
				phase_q = PH_WAIT_MAGIC;
			end
		end
		PH_LEN_LO: begin
			length_q = {8'h00, b};
			sum_q = sum_q + b;
			phase_q = PH_LEN_HI;
		end
		PH_LEN_HI: begin
			length_q[15:8] = b;
			sum_q = sum_q + b;
			phase_q = (length_q > fdsum_pkg::MAX_CONTENT) ? PH_WAIT_MAGIC : PH_CMD_LO;
		end
		PH_CMD_LO: begin
			command_q = {8'h00, b};
			phase_q = PH_CMD_HI;
		end
		PH_CMD_HI: begin
			command_q[15:8] = b;
			sum_q = sum_q + command_q;
			count_q = '0;
			phase_q = (length_q != 0) ? PH_CONTENT : PH_FLAG;
		end
		PH_CONTENT: begin
			r.content_valid = 1'b1;
			r.content_index = count_q[7:0];
			r.content_byte = b;
			sum_q = sum_q + b;
			count_q = count_q + 16'd1;
			if (count_q >= length_q)
				phase_q = PH_FLAG;
		end
		PH_FLAG: begin
			flag_q = b;
			sum_q = sum_q + b;
			phase_q = PH_SUM_LO;
		end
		PH_SUM_LO: begin
			sum_low_q = b;
			phase_q = PH_SUM_HI;
		end
		PH_SUM_HI: begin
			phase_q = (sum_q == {b, sum_low_q}) ? PH_END : PH_WAIT_MAGIC;
		end
		PH_END: begin
			if (b == fdsum_pkg::END_MAGIC) begin
				r.frame_done = 1'b1;
				r.frame_command = command_q;
				r.frame_length = length_q[fdsum_pkg::FLEN_W-1:0];
				r.flag_byte = flag_q;
			end
			phase_q = PH_WAIT_MAGIC;
		end
		default: begin
			phase_q = (b == fdsum_pkg::HEAD_MAGIC) ? PH_WAIT_HEAD2 : PH_WAIT_MAGIC;
		end
		endcase
		return r;
	endfunction

	// Appends one frame with random content to the byte queue. The defect
	// argument spoils it in one chosen way; a frame that is too long stops
	// after its length field, since the parser gives up there.
	task automatic queue_frame(input logic [7:0] head2, input int len, input logic [15:0] cmd,
		input logic [7:0] flag, input frame_defect_t defect);
		logic [15:0] len_word;
		logic [15:0] sum;
		logic [7:0]  body;
		len_word = len[15:0];
		pending_bytes.push_back(fdsum_pkg::HEAD_MAGIC);
		if (defect == FRAME_BAD_HEAD) begin
			pending_bytes.push_back(head2 ^ 8'($urandom_range(1, 255)));
			return;
		end
		pending_bytes.push_back(head2);
		pending_bytes.push_back(len_word[7:0]);
		pending_bytes.push_back(len_word[15:8]);
		if (defect == FRAME_TOO_LONG)
			return;
		pending_bytes.push_back(cmd[7:0]);
		pending_bytes.push_back(cmd[15:8]);
		sum = fdsum_pkg::HEAD_MAGIC + head2 + len_word[7:0] + len_word[15:8] + cmd;
		for (int i = 0; i < len; i++) begin
			body = 8'($urandom_range(0, 255));
			sum = sum + body;
			pending_bytes.push_back(body);
		end
		pending_bytes.push_back(flag);
		sum = sum + flag;
		if (defect == FRAME_BAD_SUM)
			sum = sum ^ 16'($urandom_range(1, 65535));
		pending_bytes.push_back(sum[7:0]);
		pending_bytes.push_back(sum[15:8]);
		if (defect == FRAME_BAD_END)
			pending_bytes.push_back(fdsum_pkg::END_MAGIC ^ 8'($urandom_range(1, 255)));
		else
			pending_bytes.push_back(fdsum_pkg::END_MAGIC);
	endtask

	// Mostly well-formed frames with random content and small lengths, mixed
	// with spoiled frames and loose noise bytes that favor the magic value.
	task automatic queue_random_traffic(input int byte_budget);
		int start_size;
		int pick;
		int len;
		int noise_len;
		start_size = pending_bytes.size();
		while (pending_bytes.size() - start_size < byte_budget) begin
			pick = $urandom_range(0, 15);
			len = (pick == 15) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			case (pick)
			10: queue_frame(head2_cfg, len, 16'($urandom), 8'($urandom), FRAME_BAD_SUM);
			11: queue_frame(head2_cfg, len, 16'($urandom), 8'($urandom), FRAME_BAD_END);
			12: queue_frame(head2_cfg, len, 16'($urandom), 8'($urandom), FRAME_BAD_HEAD);
			13: queue_frame(head2_cfg, $urandom_range(fdsum_pkg::MAX_CONTENT + 1, 65535),
				16'($urandom), 8'($urandom), FRAME_TOO_LONG);
			14: begin
				noise_len = $urandom_range(1, 6);
				repeat (noise_len)
					pending_bytes.push_back(($urandom_range(0, 3) == 0)
						? fdsum_pkg::HEAD_MAGIC : 8'($urandom_range(0, 255)));
			end
			default: queue_frame(head2_cfg, len, 16'($urandom), 8'($urandom), FRAME_GOOD);
			endcase
		end
	endtask

	// The block counts as idle once every queued byte has been taken and
	// every result has come back.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// APB write of the second head byte: setup cycle, then access cycle.
	// The predictor takes the new value only after the access edge, and only
	// while nothing is in flight.
	task automatic write_second_head(input logic [7:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= fdsum_pkg::REG_SECOND_HEAD;
		pwdata <= {{(fdsum_pkg::PDATA_W - 8){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		head2_cfg = value;
		@(negedge clk);
	endtask

	// Driver: records each accepted transaction in the predictor, then picks
	// what to offer next. A byte on offer is held until it is taken; random
	// idle bursts fall only between transactions.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && rx_ch.ready) begin
				expected_results.push_back(parse_byte(in_byte));
				bytes_taken++;
			end
			if (!in_valid || rx_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_bytes.size() == 0) begin
					in_valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(0, 15);
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					in_byte <= pending_bytes.pop_front();
				end
			end
		end
	end

	// Monitor: checks every accepted result transaction against the oldest
	// prediction, field by field, and stalls the block in random bursts.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && out_ready) begin
				got.frame_done = res_ch.frame_done;
				got.content_valid = res_ch.content_valid;
				got.content_index = res_ch.content_index;
				got.content_byte = res_ch.content_byte;
				got.frame_command = res_ch.frame_command;
				got.frame_length = res_ch.frame_length;
				got.flag_byte = res_ch.flag_byte;
				if (expected_results.size() == 0) begin
					report_error($sformatf("result %h with nothing expected", got));
				end else begin
					want = expected_results.pop_front();
					if (got.frame_done !== want.frame_done)
						report_error($sformatf("frame_done %b, expected %b",
							got.frame_done, want.frame_done));
					if (got.content_valid !== want.content_valid)
						report_error($sformatf("content_valid %b, expected %b",
							got.content_valid, want.content_valid));
					if (got.content_index !== want.content_index)
						report_error($sformatf("content_index %h, expected %h",
							got.content_index, want.content_index));
					if (got.content_byte !== want.content_byte)
						report_error($sformatf("content_byte %h, expected %h",
							got.content_byte, want.content_byte));
					if (got.frame_command !== want.frame_command)
						report_error($sformatf("frame_command %h, expected %h",
							got.frame_command, want.frame_command));
					if (got.frame_length !== want.frame_length)
						report_error($sformatf("frame_length %h, expected %h",
							got.frame_length, want.frame_length));
					if (got.flag_byte !== want.flag_byte)
						report_error($sformatf("flag_byte %h, expected %h",
							got.flag_byte, want.flag_byte));
				end
			end
			if (stall_gap > 0) begin
				stall_gap--;
				out_ready <= 1'b0;
			end else if (hold_off) begin
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_gap = $urandom_range(0, 15);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Long receiver hold-off early in the run, while bytes are still queued,
	// so the output register and skid stage fill and rx.ready drops.
	initial begin
		wait (bytes_taken >= 20);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (60) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Stimulus and end of test. Each phase runs under one setting of the
	// second head byte: the reset value, both extremes, a random value and
	// finally the magic value itself, so that a frame starts with two 0xFA.
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. A good empty frame with extreme command and flag.
		queue_frame(head2_cfg, 0, 16'hFFFF, 8'h00, FRAME_GOOD);
		// A magic byte in the second head slot is a wrong second head byte and
		// is not taken as a new frame start, so the following bytes are ignored.
		pending_bytes.push_back(fdsum_pkg::HEAD_MAGIC);
		pending_bytes.push_back(fdsum_pkg::HEAD_MAGIC);
		pending_bytes.push_back(head2_cfg);
		// Length above the limit, then a bad checksum and a bad end byte.
		queue_frame(head2_cfg, fdsum_pkg::MAX_CONTENT + 1, 16'h0000, 8'h00, FRAME_TOO_LONG);
		queue_frame(head2_cfg, 0, 16'h0000, 8'hFF, FRAME_BAD_SUM);
		queue_frame(head2_cfg, 0, 16'h8001, 8'h7E, FRAME_BAD_END);
		queue_random_traffic(20);
		wait_idle();

		write_second_head(8'h00);
		queue_random_traffic(20);
		// One frame of the largest length reaches the top content index.
		queue_frame(head2_cfg, fdsum_pkg::MAX_CONTENT, 16'($urandom), 8'($urandom),
			FRAME_GOOD);
		wait_idle();

		write_second_head(8'hFF);
		queue_random_traffic(20);
		wait_idle();

		write_second_head(8'($urandom_range(1, 254)));
		queue_random_traffic(20);
		wait_idle();

		// Last part: both sides run without idling.
		quiet = 1'b1;
		write_second_head(fdsum_pkg::HEAD_MAGIC);
		queue_random_traffic(20);
		wait_idle();

		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
